>>> src/rlp_pkg.sv
// ----------------------------------------------------------------------------
// rlp_pkg
// Shared types, constants and the character classifier of the radix literal
// parser.
// ----------------------------------------------------------------------------
package rlp_pkg;

   // Text and queue sizing
   localparam int MAX_TEXT    = 256;
   localparam int POS_W       = $clog2(MAX_TEXT + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Field widths
   localparam int CHAR_W      = 8;
   localparam int VALUE_W     = 64;
   localparam int STATUS_W    = 2;
   localparam int CONS_W      = 9;
   localparam int RSP_TDATA_W = 80;

   // Overflow limits checked before each digit
   localparam logic [VALUE_W-1:0] ALL_ONES = {VALUE_W{1'b1}};
   localparam logic [VALUE_W-1:0] LIM_HEX  = ALL_ONES / 64'd16;
   localparam logic [VALUE_W-1:0] LIM_DEC  = ALL_ONES / 64'd10;
   localparam logic [VALUE_W-1:0] LIM_OCT  = ALL_ONES / 64'd8;
   localparam logic [VALUE_W-1:0] LIM_BIN  = ALL_ONES / 64'd2;

   // Suffix scale: each step multiplies by 1024
   localparam int SUFFIX_STEP = $clog2(1024);

   typedef enum logic [1:0] {
      SG_NONE = 2'd0,
      SG_NEG  = 2'd1,
      SG_INV  = 2'd2
   } sign_type;

   typedef enum logic [2:0] {
      RX_GUESS = 3'd0,
      RX_HEX   = 3'd1,
      RX_DEC   = 3'd2,
      RX_OCT   = 3'd3,
      RX_BIN   = 3'd4
   } radix_type;

   typedef enum logic [2:0] {
      PFX_NONE = 3'd0,
      PFX_H    = 3'd1,
      PFX_O    = 3'd2,
      PFX_B    = 3'd3,
      PFX_D    = 3'd4
   } prefix_type;

   typedef enum logic [2:0] {
      SFX_NONE = 3'd0,
      SFX_K    = 3'd1,
      SFX_M    = 3'd2,
      SFX_G    = 3'd3,
      SFX_T    = 3'd4,
      SFX_P    = 3'd5
   } suffix_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_PARSED  = 2'd0,
      ST_NONE    = 2'd1,
      ST_UNRECOG = 2'd2
   } status_type;

   typedef enum logic [6:0] {
      PH_SKIP   = 7'b0000001,
      PH_PREFIX = 7'b0000010,
      PH_PEND   = 7'b0000100,
      PH_RUN    = 7'b0001000,
      PH_OK     = 7'b0010000,
      PH_NONE   = 7'b0100000,
      PH_ERR    = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic       is_dig;
      logic       is_letter;
      logic [3:0] dval;
      logic       is_blank;
      logic       is_nul;
      logic       is_sign;
      sign_type   sign;
      prefix_type pfx;
      logic       is_x;
      suffix_type sfx;
   } char_class_type;

   typedef struct packed {
      char_class_type cls;
      logic           last;
   } queue_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_flags_type;

   typedef struct packed {
      phase_type          phase;
      sign_type           sign;
      radix_type          radix;
      logic [3:0]         flags;
      logic [VALUE_W-1:0] hex;
      logic [VALUE_W-1:0] dec;
      logic [VALUE_W-1:0] oct;
      logic [VALUE_W-1:0] bin;
      logic [3:0]         ovf;
      logic [1:0]         derr;
      logic [CONS_W-1:0]  cons;
   } parse_state_type;

   localparam parse_state_type ST_RESET = '{
      phase: PH_SKIP, sign: SG_NONE, radix: RX_GUESS, flags: 4'd0,
      hex: '0, dec: '0, oct: '0, bin: '0, ovf: 4'd0, derr: 2'd0, cons: '0
   };

   function automatic char_class_type classify(input logic [CHAR_W-1:0] c);
      char_class_type r;
      logic           lower;
      logic           upper;
      r       = '0;
      lower   = (c >= 8'h61) && (c <= 8'h66);
      upper   = (c >= 8'h41) && (c <= 8'h46);
      r.is_dig    = (c >= 8'h30) && (c <= 8'h39);
      r.is_letter = lower || upper;
      if (r.is_dig) begin
         r.dval = c[3:0];
      end else if (r.is_letter) begin
         r.dval = c[3:0] + 4'd9;
      end
      r.is_blank = (c == 8'h20) || (c == 8'h09);
      r.is_nul   = (c == 8'h00);
      r.is_sign  = (c == 8'h2d) || (c == 8'h2b) || (c == 8'h7e);
      if (c == 8'h2d) begin
         r.sign = SG_NEG;
      end else if (c == 8'h7e) begin
         r.sign = SG_INV;
      end
      if ((c == 8'h68) || (c == 8'h48)) begin
         r.pfx = PFX_H;
      end else if ((c == 8'h6f) || (c == 8'h4f)) begin
         r.pfx = PFX_O;
      end else if ((c == 8'h62) || (c == 8'h42)) begin
         r.pfx = PFX_B;
      end else if ((c == 8'h64) || (c == 8'h44)) begin
         r.pfx = PFX_D;
      end
      r.is_x = (c == 8'h78);
      if ((c == 8'h6b) || (c == 8'h4b)) begin
         r.sfx = SFX_K;
      end else if ((c == 8'h6d) || (c == 8'h4d)) begin
         r.sfx = SFX_M;
      end else if ((c == 8'h67) || (c == 8'h47)) begin
         r.sfx = SFX_G;
      end else if ((c == 8'h74) || (c == 8'h54)) begin
         r.sfx = SFX_T;
      end else if ((c == 8'h70) || (c == 8'h50)) begin
         r.sfx = SFX_P;
      end
      return r;
   endfunction

   // End-byte class and classes replayed when a prefix proves to be a digit
   localparam char_class_type CLS_NUL  = classify(8'h00);
   localparam char_class_type CLS_B    = classify(8'h62);
   localparam char_class_type CLS_D    = classify(8'h64);
   localparam char_class_type CLS_ZERO = classify(8'h30);

endpackage

>>> src/rlp_front.sv
// ----------------------------------------------------------------------------
// rlp_front
// Input side: accept characters, classify them and push them to the queue.
// ----------------------------------------------------------------------------
module rlp_front import rlp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic [CHAR_W-1:0]     req_tdata,
   input  logic                  req_tlast,
   output logic                  req_tready,
   input  queue_flags_type       q_flags,
   output logic                  q_push,
   output queue_entry_type       q_entry
);

   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   logic             in_range;

   assign req_tready = !q_flags.full;
   assign q_push     = req_tvalid && req_tready;
   assign in_range   = (pos_ff < POS_W'(MAX_TEXT));

   // Past the text limit a character counts as end of text
   assign q_entry.cls  = classify(in_range ? req_tdata : CHAR_W'(0));
   assign q_entry.last = req_tlast;

   always_comb begin
      pos_in = pos_ff;
      if (q_push) begin
         if (req_tlast) begin
            pos_in = '0;
         end else if (in_range) begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

>>> src/rlp_queue.sv
// ----------------------------------------------------------------------------
// rlp_queue
// Short queue of classified characters between front and back.
// ----------------------------------------------------------------------------
module rlp_queue import rlp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            wr_en,
   input  queue_entry_type wr_data,
   input  logic            rd_en,
   output queue_entry_type rd_data,
   output queue_flags_type flags
);

   queue_entry_type   store_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wptr_ff;
   logic [QPTR_W-1:0] wptr_in;
   logic [QPTR_W-1:0] rptr_ff;
   logic [QPTR_W-1:0] rptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;

   assign flags.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign flags.empty = (count_ff == '0);
   assign rd_data     = store_ff[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      if (wr_en) begin
         wptr_in = (wptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + QPTR_W'(1);
      end
      if (rd_en) begin
         rptr_in = (rptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + QPTR_W'(1);
      end
      case ({wr_en, rd_en})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (!flags.full || rd_en))
      else $error("push into full queue");

   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> !flags.empty)
      else $error("pop from empty queue");

endmodule

>>> src/rlp_back.sv
// ----------------------------------------------------------------------------
// rlp_back
// Parse engine: run the literal grammar and the four accumulators, one
// character per step, and hold the result in an output register.
// ----------------------------------------------------------------------------
module rlp_back import rlp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  queue_flags_type    q_flags,
   input  queue_entry_type    q_head,
   output logic               q_pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [VALUE_W-1:0] rsp_value,
   output status_type         rsp_status,
   output logic [CONS_W-1:0]  rsp_consumed
);

   parse_state_type    st_ff;
   parse_state_type    st_in;
   parse_state_type    calc;
   logic               end_pend_ff;
   logic               end_pend_in;
   char_class_type     cur;
   char_class_type     run_cls;
   radix_type          run_rad;
   radix_type          sel;
   logic               run_go;
   logic               do_pfx;
   logic               replay;
   logic               member;
   logic               bad;
   logic               run_inc;
   logic [1:0]         pre_inc;
   logic [VALUE_W-1:0] fin_val;
   logic               step_ok;
   logic               emit;
   logic               out_busy;
   logic               advance;
   logic               out_load;
   logic               out_valid_ff;
   logic               out_valid_in;
   logic [VALUE_W-1:0] out_value_ff;
   logic [VALUE_W-1:0] out_value_in;
   status_type         out_status_ff;
   status_type         out_status_in;
   logic [CONS_W-1:0]  out_cons_ff;
   logic [CONS_W-1:0]  out_cons_in;

   // During the end step the engine sees a zero byte
   assign cur = end_pend_ff ? CLS_NUL : q_head.cls;

   // Next parse state for the current character
   always_comb begin
      calc    = st_ff;
      run_go  = 1'b0;
      do_pfx  = 1'b0;
      run_cls = cur;
      run_rad = st_ff.radix;
      replay  = 1'b0;
      pre_inc = 2'd0;
      run_inc = 1'b0;
      member  = 1'b0;
      bad     = 1'b0;
      sel     = RX_GUESS;
      fin_val = '0;

      case (st_ff.phase)
         PH_SKIP: begin
            if (cur.is_blank) begin
               pre_inc = 2'd1;
            end else if (cur.is_nul) begin
               calc.phase = PH_NONE;
            end else if (cur.is_sign) begin
               calc.sign  = cur.sign;
               pre_inc    = 2'd1;
               calc.phase = PH_PREFIX;
            end else begin
               do_pfx = 1'b1;
            end
         end
         PH_PREFIX: begin
            do_pfx = 1'b1;
         end
         PH_PEND: begin
            calc.phase = PH_RUN;
            case (st_ff.radix)
               RX_BIN: begin
                  if (cur.is_dig && (cur.dval[3:1] == 3'd0)) begin
                     pre_inc = 2'd1;
                     run_go  = 1'b1;
                     run_rad = RX_BIN;
                  end else begin
                     // b was a hex digit: replay it, keep the head
                     calc.radix = RX_HEX;
                     run_go     = 1'b1;
                     run_cls    = CLS_B;
                     run_rad    = RX_HEX;
                     replay     = 1'b1;
                  end
               end
               RX_DEC: begin
                  if (cur.is_dig) begin
                     pre_inc = 2'd1;
                     run_go  = 1'b1;
                     run_rad = RX_DEC;
                  end else begin
                     calc.radix = RX_HEX;
                     run_go     = 1'b1;
                     run_cls    = CLS_D;
                     run_rad    = RX_HEX;
                     replay     = 1'b1;
                  end
               end
               default: begin
                  if (cur.is_x) begin
                     calc.radix = RX_HEX;
                     pre_inc    = 2'd2;
                  end else begin
                     // leading zero was a digit of its own
                     run_go  = 1'b1;
                     run_cls = CLS_ZERO;
                     run_rad = RX_GUESS;
                     replay  = 1'b1;
                  end
               end
            endcase
         end
         PH_RUN: begin
            run_go = 1'b1;
         end
         default: ;
      endcase

      if (do_pfx) begin
         case (cur.pfx)
            PFX_H: begin
               calc.radix = RX_HEX;
               pre_inc    = 2'd1;
               calc.phase = PH_RUN;
            end
            PFX_O: begin
               calc.radix = RX_OCT;
               pre_inc    = 2'd1;
               calc.phase = PH_RUN;
            end
            PFX_B: begin
               calc.radix = RX_BIN;
               calc.phase = PH_PEND;
            end
            PFX_D: begin
               calc.radix = RX_DEC;
               calc.phase = PH_PEND;
            end
            default: begin
               calc.radix = RX_GUESS;
               if (cur.is_dig && (cur.dval == 4'd0)) begin
                  calc.phase = PH_PEND;
               end else begin
                  calc.phase = PH_RUN;
                  run_go     = 1'b1;
                  run_rad    = RX_GUESS;
               end
            end
         endcase
      end

      if (run_go) begin
         member = ((run_rad == RX_HEX) || (run_rad == RX_GUESS)) ?
                  (run_cls.is_dig || run_cls.is_letter) : run_cls.is_dig;
         if (!member) begin
            // End of the digit run: pick the radix and finish the value
            sel = run_rad;
            if (run_rad == RX_GUESS) begin
               if (st_ff.flags[3]) begin
                  sel = RX_HEX;
               end else if (st_ff.flags[2]) begin
                  sel = RX_DEC;
               end else if (st_ff.flags[1]) begin
                  sel = RX_OCT;
               end else if (st_ff.flags[0]) begin
                  sel = RX_BIN;
               end
            end
            case (sel)
               RX_HEX: begin
                  fin_val = st_ff.hex;
                  bad     = st_ff.ovf[0];
               end
               RX_DEC: begin
                  fin_val = st_ff.dec;
                  bad     = st_ff.ovf[1];
               end
               RX_OCT: begin
                  fin_val = st_ff.oct;
                  bad     = st_ff.ovf[2] || st_ff.derr[0];
               end
               RX_BIN: begin
                  fin_val = st_ff.bin;
                  bad     = st_ff.ovf[3] || st_ff.derr[1];
               end
               default: bad = 1'b1;
            endcase
            if ((st_ff.flags == 4'd0) || bad) begin
               calc.phase = PH_ERR;
            end else begin
               case (run_cls.sfx)
                  SFX_K:   fin_val = fin_val << SUFFIX_STEP;
                  SFX_M:   fin_val = fin_val << (2 * SUFFIX_STEP);
                  SFX_G:   fin_val = fin_val << (3 * SUFFIX_STEP);
                  SFX_T:   fin_val = fin_val << (4 * SUFFIX_STEP);
                  SFX_P:   fin_val = fin_val << (5 * SUFFIX_STEP);
                  default: ;
               endcase
               run_inc = (run_cls.sfx != SFX_NONE);
               case (st_ff.sign)
                  SG_NEG:  fin_val = ~fin_val + VALUE_W'(1);
                  SG_INV:  fin_val = ~fin_val;
                  default: ;
               endcase
               calc.hex   = fin_val;
               calc.phase = PH_OK;
            end
         end else begin
            // Digit: advance every accumulator that can take it
            if (st_ff.hex > LIM_HEX) begin
               calc.ovf[0] = 1'b1;
            end else begin
               calc.hex = {st_ff.hex[VALUE_W-5:0], run_cls.dval};
            end
            if (run_cls.is_dig) begin
               if (st_ff.dec > LIM_DEC) begin
                  calc.ovf[1] = 1'b1;
               end else begin
                  calc.dec = {st_ff.dec[VALUE_W-4:0], 3'b000}
                           + {st_ff.dec[VALUE_W-2:0], 1'b0}
                           + VALUE_W'(run_cls.dval);
               end
               if (st_ff.oct > LIM_OCT) begin
                  calc.ovf[2] = 1'b1;
               end else if (run_cls.dval[3]) begin
                  calc.derr[0] = 1'b1;
               end else begin
                  calc.oct = {st_ff.oct[VALUE_W-4:0], run_cls.dval[2:0]};
               end
               if (st_ff.bin > LIM_BIN) begin
                  calc.ovf[3] = 1'b1;
               end else if (run_cls.dval[3:1] != 3'd0) begin
                  calc.derr[1] = 1'b1;
               end else begin
                  calc.bin = {st_ff.bin[VALUE_W-2:0], run_cls.dval[0]};
               end
            end
            if (st_ff.flags == 4'd0) begin
               if (run_cls.is_dig && (run_cls.dval == 4'd0)) begin
                  calc.flags = 4'b0001;
               end else if (run_cls.is_dig) begin
                  calc.flags = 4'b0100;
               end else begin
                  calc.flags = 4'b1000;
               end
            end else if (!run_cls.is_dig) begin
               calc.flags = st_ff.flags | 4'b1000;
            end else if (run_cls.dval[3]) begin
               calc.flags = st_ff.flags | 4'b0100;
            end else if ((run_cls.dval[3:1] != 3'd0) && (st_ff.flags == 4'b0001)) begin
               calc.flags = 4'b0010;
            end
            run_inc = 1'b1;
         end
      end

      calc.cons = st_ff.cons + CONS_W'(pre_inc) + CONS_W'(run_inc);
   end

   // Step control and result register
   always_comb begin
      step_ok  = end_pend_ff || !q_flags.empty;
      emit     = end_pend_ff && !replay;
      out_busy = out_valid_ff && !rsp_tready;
      advance  = step_ok && !(emit && out_busy);
      out_load = advance && emit;
      q_pop    = advance && !end_pend_ff && !replay;

      st_in       = st_ff;
      end_pend_in = end_pend_ff;
      if (advance) begin
         st_in = calc;
         if (q_pop && q_head.last) begin
            end_pend_in = 1'b1;
         end
      end
      if (out_load) begin
         st_in       = ST_RESET;
         end_pend_in = 1'b0;
      end

      case (calc.phase)
         PH_OK: begin
            out_value_in  = calc.hex;
            out_status_in = ST_PARSED;
            out_cons_in   = calc.cons;
         end
         PH_NONE: begin
            out_value_in  = '0;
            out_status_in = ST_NONE;
            out_cons_in   = calc.cons;
         end
         default: begin
            out_value_in  = ALL_ONES;
            out_status_in = ST_UNRECOG;
            out_cons_in   = '0;
         end
      endcase

      out_valid_in = out_valid_ff && !rsp_tready;
      if (out_load) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_RESET;
         end_pend_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         end_pend_ff  <= end_pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_value_ff  <= out_value_in;
         out_status_ff <= out_status_in;
         out_cons_ff   <= out_cons_in;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_value    = out_value_ff;
   assign rsp_status   = out_status_ff;
   assign rsp_consumed = out_cons_ff;

   a_emit_at_end: assert property (@(posedge clock) disable iff (reset)
      out_load |-> end_pend_ff)
      else $error("result loaded outside end step");

   a_clear_after_emit: assert property (@(posedge clock) disable iff (reset)
      out_load |=> ((st_ff.phase == PH_SKIP) && (st_ff.cons == '0) && !end_pend_ff))
      else $error("parse state not cleared after result");

   a_replay_from_pend: assert property (@(posedge clock) disable iff (reset)
      (advance && replay) |=> ((st_ff.phase == PH_RUN) && !$past(q_pop)))
      else $error("prefix replay left wrong phase or popped");

endmodule

>>> src/radix_literal_parser.sv
// ----------------------------------------------------------------------------
// radix_literal_parser
// Result: loaded by the end step run after the last character (and after
//   any replay of a b/d/0 prefix); the step waits while a result is held.
// Throughput: one character per cycle while the queue has room; the engine
//   adds one end step per text and one replay step when b, d or 0 is a digit.
// Reset: synchronous, active high; empties the queue, clears the parse state
//   and drops any result not yet taken.
// ----------------------------------------------------------------------------
module radix_literal_parser import rlp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // req_tdata: [7:0] character
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [CHAR_W-1:0]      req_tdata,
   input  logic                   req_tlast,
   // rsp_tdata: [63:0] value, [65:64] status, [74:66] consumed, [79:75] zero
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   queue_flags_type    q_flags;
   logic               q_push;
   logic               q_pop;
   queue_entry_type    q_entry;
   queue_entry_type    q_head;
   logic [VALUE_W-1:0] rsp_value;
   status_type         rsp_status;
   logic [CONS_W-1:0]  rsp_consumed;

   // Front: classify each item and push it while the queue has room
   rlp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .q_flags    (q_flags),
      .q_push     (q_push),
      .q_entry    (q_entry)
   );

   // Queue: decouple the front from stalls of the parse engine
   rlp_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (q_entry),
      .rd_en   (q_pop),
      .rd_data (q_head),
      .flags   (q_flags)
   );

   // Back: run the grammar and accumulators, hold the result until taken
   rlp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_flags      (q_flags),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_value    (rsp_value),
      .rsp_status   (rsp_status),
      .rsp_consumed (rsp_consumed)
   );

   // Pack result fields, lowest field in the lowest bits, pad to whole bytes
   assign rsp_tdata = {(RSP_TDATA_W - VALUE_W - STATUS_W - CONS_W)'(0),
                       rsp_consumed, STATUS_W'(rsp_status), rsp_value};

endmodule
